### sv/htd_pkg.sv
// Shared constants for the Huffman table decoder: field widths and action codes.
`default_nettype none

package htd_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DECODE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

endpackage

`default_nettype wire

### sv/huffman_table_decoder_unit.sv
// Huffman decoder that builds and walks a binary decode tree held in one memory.
//
// Requests enter on start while busy is low; action picks the kind:
//   load    - insert symbol_value with code_bits/code_len into the tree;
//             busy stays high while it walks the path, no result.
//   decode  - walk data_byte, bit 7 first, one tree read per bit; symbols
//             leave on symbol/last_of_run/stream_done, each marked by a
//             single-cycle symbol_strobe. busy stays high through the
//             tree reads (the read-to-next-address loop through the tree
//             memory) and the release of the held-back last symbol; a new
//             byte is taken only once busy is low again.
//   restart - clear tree and counters with a pass over the memory.
// Loads refused for their code_len or symbol_value, unknown actions and
// decodes after the total is reached are taken with busy staying low. The
// register symbol_total is written through symbol_total_we; write it only
// while busy is low. After rst (synchronous, active high), and after every
// restart, busy stays high while the clearing pass writes each entry.
// The receiver cannot stall: every strobed result must be taken.
`default_nettype none

module huffman_table_decoder_unit
  import htd_pkg::*;
#(
  parameter int unsigned TREE_ENTRIES  = 512,
  parameter int unsigned ALPHABET_SIZE = 256,
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [SYM_W-1:0]    symbol_value,
  input  wire logic [CODE_W-1:0]   code_bits,
  input  wire logic [LEN_W-1:0]    code_len,
  input  wire logic [BYTE_W-1:0]   data_byte,
  input  wire logic                symbol_total_we,
  input  wire logic [COUNT_W-1:0]  symbol_total,
  output logic                     symbol_strobe,
  output logic [SYM_W-1:0]         symbol,
  output logic                     last_of_run,
  output logic                     stream_done
);

  localparam int unsigned AW  = $clog2(TREE_ENTRIES);
  localparam int unsigned VW  = (AW > SYM_W) ? AW : SYM_W;
  localparam int unsigned LBW = (MAX_CODE_BITS > 2) ? $clog2(MAX_CODE_BITS) : 1;
  localparam int unsigned CEW = 1 << LBW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_LDLEAF, S_WALK, S_FLUSH
  } state_t;

  // entry: leaf flag on top, then symbol or node number; all zero is empty
  logic [VW:0] tree_mem [TREE_ENTRIES];
  logic [VW:0] mem_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [VW:0] mem_wdata;

  state_t state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [AW-1:0] node_count, node_count_next;
  logic [AW-1:0] walk, walk_next;
  logic [COUNT_W-1:0] decoded, decoded_next;
  logic [COUNT_W-1:0] target;

  logic [AW-1:0] ld_idx, ld_idx_next;
  logic          ld_first, ld_first_next;
  logic          ld_leaf_ok, ld_leaf_ok_next;
  logic [LBW-1:0] lbit, lbit_next;
  logic [SYM_W-1:0] ld_sym, ld_sym_next;
  logic [CODE_W-1:0] ld_code, ld_code_next;
  logic [CEW-1:0] code_ext;

  logic [BYTE_W-1:0] dbyte, dbyte_next;
  logic [2:0]        dbit, dbit_next;
  logic              cur_oob, cur_oob_next;

  logic             pend_valid, pend_valid_next;
  logic [SYM_W-1:0] pend_sym, pend_sym_next;
  logic             pend_done, pend_done_next;

  logic             strobe_next, last_next, done_next;
  logic [SYM_W-1:0] symbol_next;

  logic          fwd_hit;
  logic [VW:0]   fwd_data;
  logic [VW:0]   ent;
  logic          ent_leaf, ent_empty;
  logic [AW-1:0] ent_node;

  logic [AW:0]   cand;
  logic          insert;
  logic [AW-1:0] node;
  logic          is_leaf, reached;
  logic [SYM_W-1:0] leaf_sym;
  logic [COUNT_W-1:0] decoded_inc;
  logic [AW-1:0] nwalk;

  assign busy     = (state != S_IDLE);
  assign code_ext = CEW'(ld_code);

  assign ent       = fwd_hit ? fwd_data : mem_q;
  assign ent_leaf  = ent[VW];
  assign ent_empty = (ent[VW-1:0] == '0);
  assign ent_node  = ent_leaf ? '0 : ent[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
    mem_q    <= tree_mem[mem_raddr];
    fwd_hit  <= mem_we && (mem_waddr == mem_raddr);
    fwd_data <= mem_wdata;
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    node_count_next = node_count;
    walk_next       = walk;
    decoded_next    = decoded;
    ld_idx_next     = ld_idx;
    ld_first_next   = ld_first;
    ld_leaf_ok_next = ld_leaf_ok;
    lbit_next       = lbit;
    ld_sym_next     = ld_sym;
    ld_code_next    = ld_code;
    dbyte_next      = dbyte;
    dbit_next       = dbit;
    cur_oob_next    = cur_oob;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    pend_done_next  = pend_done;
    strobe_next     = 1'b0;
    last_next       = 1'b0;
    done_next       = 1'b0;
    symbol_next     = symbol;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_raddr       = '0;
    cand            = '0;
    insert          = 1'b0;
    node            = ent_node;
    is_leaf         = cur_oob || ent_leaf || ent_empty;
    leaf_sym        = (cur_oob || !ent_leaf) ? '0 : ent[SYM_W-1:0];
    decoded_inc     = decoded + COUNT_W'(1);
    reached         = (decoded_inc == target);
    nwalk           = is_leaf ? AW'(1) : ent_node;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = (clr_addr == AW'(1)) ? {1'b0, VW'(1)} : '0;
        if (clr_addr == AW'(TREE_ENTRIES - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_LOAD: begin
              if (code_len != '0 &&
                  COUNT_W'(code_len) <= COUNT_W'(MAX_CODE_BITS) &&
                  COUNT_W'(symbol_value) < COUNT_W'(ALPHABET_SIZE)) begin
                mem_raddr     = AW'(1);
                ld_idx_next   = AW'(1);
                ld_first_next = 1'b1;
                lbit_next     = LBW'(code_len - LEN_W'(1));
                ld_sym_next   = symbol_value;
                ld_code_next  = code_bits;
                state_next    = S_LOAD;
              end
            end
            ACT_DECODE: begin
              if (decoded < target) begin
                cand         = {walk, data_byte[BYTE_W-1]};
                mem_raddr    = cand[AW-1:0];
                cur_oob_next = (cand >= (AW+1)'(TREE_ENTRIES));
                dbyte_next   = data_byte;
                dbit_next    = 3'd7;
                state_next   = S_WALK;
              end
            end
            ACT_RESTART: begin
              clr_addr_next   = '0;
              node_count_next = AW'(1);
              walk_next       = AW'(1);
              decoded_next    = '0;
              state_next      = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      S_LOAD: begin
        // grow an internal node over an empty or leaf entry on the path
        insert = !ld_first && (ent_leaf || ent_empty) &&
                 (({1'b0, node_count} + (AW+1)'(1)) < (AW+1)'(TREE_ENTRIES));
        if (insert) begin
          node_count_next = node_count + AW'(1);
          node            = node_count + AW'(1);
          mem_we          = 1'b1;
          mem_waddr       = ld_idx;
          mem_wdata       = {1'b0, VW'(node_count + AW'(1))};
        end
        if (lbit == '0) begin
          cand            = {node, ld_code[0]};
          ld_idx_next     = cand[AW-1:0];
          ld_leaf_ok_next = (cand < (AW+1)'(TREE_ENTRIES));
          state_next      = S_LDLEAF;
        end else begin
          cand = {node, code_ext[lbit]};
          if (cand >= (AW+1)'(TREE_ENTRIES)) begin
            state_next = S_IDLE;
          end else begin
            mem_raddr     = cand[AW-1:0];
            ld_idx_next   = cand[AW-1:0];
            ld_first_next = 1'b0;
            lbit_next     = lbit - LBW'(1);
          end
        end
      end

      S_LDLEAF: begin
        if (ld_leaf_ok) begin
          mem_we    = 1'b1;
          mem_waddr = ld_idx;
          mem_wdata = {1'b1, VW'(ld_sym)};
        end
        state_next = S_IDLE;
      end

      S_WALK: begin
        if (is_leaf) begin
          decoded_next = decoded_inc;
          // hold each symbol back until the next is found so the last one of the byte can be marked
          if (pend_valid) begin
            strobe_next = 1'b1;
            symbol_next = pend_sym;
          end
          pend_valid_next = 1'b1;
          pend_sym_next   = leaf_sym;
          pend_done_next  = reached;
        end
        if (!(is_leaf && reached)) begin
          walk_next = nwalk;
        end
        if ((is_leaf && reached) || dbit == 3'd0) begin
          state_next = (is_leaf || pend_valid) ? S_FLUSH : S_IDLE;
        end else begin
          cand         = {nwalk, dbyte[dbit - 3'd1]};
          mem_raddr    = cand[AW-1:0];
          cur_oob_next = (cand >= (AW+1)'(TREE_ENTRIES));
          dbit_next    = dbit - 3'd1;
        end
      end

      S_FLUSH: begin
        strobe_next     = 1'b1;
        symbol_next     = pend_sym;
        last_next       = 1'b1;
        done_next       = pend_done;
        pend_valid_next = 1'b0;
        state_next      = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      node_count    <= AW'(1);
      walk          <= AW'(1);
      decoded       <= '0;
      target        <= '0;
      pend_valid    <= 1'b0;
      symbol_strobe <= 1'b0;
      last_of_run   <= 1'b0;
      stream_done   <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      node_count    <= node_count_next;
      walk          <= walk_next;
      decoded       <= decoded_next;
      pend_valid    <= pend_valid_next;
      symbol_strobe <= strobe_next;
      last_of_run   <= last_next;
      stream_done   <= done_next;
      if (symbol_total_we) begin
        target <= symbol_total;
      end
    end
    ld_idx     <= ld_idx_next;
    ld_first   <= ld_first_next;
    ld_leaf_ok <= ld_leaf_ok_next;
    lbit       <= lbit_next;
    ld_sym     <= ld_sym_next;
    ld_code    <= ld_code_next;
    dbyte      <= dbyte_next;
    dbit       <= dbit_next;
    cur_oob    <= cur_oob_next;
    pend_sym   <= pend_sym_next;
    pend_done  <= pend_done_next;
    symbol     <= symbol_next;
  end

endmodule

`default_nettype wire

### tb/sv/htd_symbol_checker.sv
// Checker for huffman_table_decoder_unit: mirrors the decode tree and compares each symbol.
module htd_symbol_checker
  import htd_pkg::*;
#(
  parameter int unsigned TREE_ENTRIES  = 512,
  parameter int unsigned ALPHABET_SIZE = 256,
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [SYM_W-1:0]    symbol_value,
  input  wire logic [CODE_W-1:0]   code_bits,
  input  wire logic [LEN_W-1:0]    code_len,
  input  wire logic [BYTE_W-1:0]   data_byte,
  input  wire logic                symbol_total_we,
  input  wire logic [COUNT_W-1:0]  symbol_total,
  input  wire logic                symbol_strobe,
  input  wire logic [SYM_W-1:0]    symbol,
  input  wire logic                last_of_run,
  input  wire logic                stream_done,
  output int unsigned              mismatch_count,
  output int unsigned              pending_symbols,
  output int unsigned              symbols_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODE_W = $clog2(TREE_ENTRIES);

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_run;
    logic             stream_done;
  } decoded_symbol_t;

  // Each entry is empty (zero, not leaf), internal (node number) or a leaf (symbol).
  logic [NODE_W-1:0]  tree_val [TREE_ENTRIES];
  bit                 tree_is_leaf [TREE_ENTRIES];
  logic [NODE_W-1:0]  node_count;
  logic [NODE_W-1:0]  walk_node;
  logic [COUNT_W-1:0] total_reg;
  logic [COUNT_W-1:0] decoded_count;
  decoded_symbol_t    expected_symbols [$];
  int unsigned        errors;
  int unsigned        checked;

  function automatic bit slot_terminal(input int unsigned idx);
    if (idx >= TREE_ENTRIES) return 1'b1;
    return tree_is_leaf[idx] || tree_val[idx] == '0;
  endfunction

  function automatic logic [SYM_W-1:0] slot_symbol(input int unsigned idx);
    if (idx >= TREE_ENTRIES || !tree_is_leaf[idx]) return '0;
    return tree_val[idx][SYM_W-1:0];
  endfunction

  function automatic int unsigned slot_node(input int unsigned idx);
    if (idx >= TREE_ENTRIES || tree_is_leaf[idx]) return 0;
    return tree_val[idx];
  endfunction

  function automatic void clear_tree();
    for (int i = 0; i < TREE_ENTRIES; i++) begin
      tree_val[i] = '0;
      tree_is_leaf[i] = 1'b0;
    end
    tree_val[1] = NODE_W'(1);
    node_count = NODE_W'(1);
    walk_node = NODE_W'(1);
    decoded_count = '0;
  endfunction

  function automatic void insert_code(input int unsigned sym, input int unsigned code,
                                      input int unsigned len);
    int unsigned idx;
    int unsigned leaf_idx;
    int          pos;
    if (len == 0 || len > MAX_CODE_BITS || sym >= ALPHABET_SIZE) return;
    idx = 1;
    for (pos = int'(len) - 1; pos > 0; pos--) begin
      idx = (slot_node(idx) << 1) + ((code >> pos) & 1);
      // drop the rest of the path once it leaves the store
      if (idx >= TREE_ENTRIES) return;
      if (slot_terminal(idx) && node_count + 1 < TREE_ENTRIES) begin
        node_count = node_count + 1'b1;
        tree_val[idx] = node_count;
        tree_is_leaf[idx] = 1'b0;
      end
    end
    leaf_idx = (slot_node(idx) << 1) + (code & 1);
    if (leaf_idx < TREE_ENTRIES) begin
      tree_val[leaf_idx] = NODE_W'(sym);
      tree_is_leaf[leaf_idx] = 1'b1;
    end
  endfunction

  function automatic void walk_byte(input logic [BYTE_W-1:0] data_val);
    decoded_symbol_t item;
    int unsigned     idx;
    int unsigned     produced;
    int              pos;
    produced = 0;
    for (pos = BYTE_W - 1; pos >= 0; pos--) begin
      if (decoded_count >= total_reg) break;
      idx = (int'(walk_node) << 1) + data_val[pos];
      if (slot_terminal(idx)) begin
        decoded_count = decoded_count + 1'b1;
        item.symbol = slot_symbol(idx);
        item.last_of_run = 1'b0;
        item.stream_done = (decoded_count == total_reg);
        expected_symbols.push_back(item);
        produced++;
        if (item.stream_done) break;
        walk_node = NODE_W'(1);
      end else begin
        walk_node = NODE_W'(slot_node(idx));
      end
    end
    // flag the final symbol of this byte
    if (produced > 0) begin
      item = expected_symbols.pop_back();
      item.last_of_run = 1'b1;
      expected_symbols.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    decoded_symbol_t want;
    if (rst) begin
      clear_tree();
      total_reg = '0;
      expected_symbols.delete();
    end else begin
      if (symbol_strobe) begin
        if (expected_symbols.size() == 0) begin
          $display("%0t ns: expected no symbol, got symbol %0d last %0b done %0b",
                   $time, symbol, last_of_run, stream_done);
          errors++;
        end else begin
          want = expected_symbols.pop_front();
          checked++;
          if (symbol !== want.symbol) begin
            $display("%0t ns: symbol expected %0d, got %0d", $time, want.symbol, symbol);
            errors++;
          end
          if (last_of_run !== want.last_of_run) begin
            $display("%0t ns: last_of_run expected %0b, got %0b",
                     $time, want.last_of_run, last_of_run);
            errors++;
          end
          if (stream_done !== want.stream_done) begin
            $display("%0t ns: stream_done expected %0b, got %0b",
                     $time, want.stream_done, stream_done);
            errors++;
          end
        end
      end
      if (symbol_total_we) total_reg = symbol_total;
      if (start && !busy) begin
        case (action)
          ACT_LOAD:    insert_code(symbol_value, code_bits, code_len);
          ACT_DECODE:  walk_byte(data_byte);
          ACT_RESTART: clear_tree();
          default: ;
        endcase
      end
    end
    mismatch_count <= errors;
    pending_symbols <= expected_symbols.size();
    symbols_checked <= checked;
  end

endmodule

### tb/sv/tb.sv
// Top-level testbench for huffman_table_decoder_unit: stimulus, clock, reset and verdict.
module tb
  import htd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned         ITEM_TARGET = 420;
  localparam int unsigned         CYCLE_LIMIT = 400_000;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [COUNT_W-1:0]  TOTAL_MAX   = '1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [ACTION_W-1:0] action = ACT_LOAD;
  logic [SYM_W-1:0]    symbol_value = '0;
  logic [CODE_W-1:0]   code_bits = '0;
  logic [LEN_W-1:0]    code_len = '0;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                symbol_total_we = 1'b0;
  logic [COUNT_W-1:0]  symbol_total = '0;
  logic                symbol_strobe;
  logic [SYM_W-1:0]    symbol;
  logic                last_of_run;
  logic                stream_done;

  int unsigned mismatch_count;
  int unsigned pending_symbols;
  int unsigned symbols_checked;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned decodes_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned unknown_sent = 0;
  bit          idle_on = 1'b1;

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  huffman_table_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .symbol_value(symbol_value),
    .code_bits(code_bits),
    .code_len(code_len),
    .data_byte(data_byte),
    .symbol_total_we(symbol_total_we),
    .symbol_total(symbol_total),
    .symbol_strobe(symbol_strobe),
    .symbol(symbol),
    .last_of_run(last_of_run),
    .stream_done(stream_done)
  );

  htd_symbol_checker chk (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .symbol_value(symbol_value),
    .code_bits(code_bits),
    .code_len(code_len),
    .data_byte(data_byte),
    .symbol_total_we(symbol_total_we),
    .symbol_total(symbol_total),
    .symbol_strobe(symbol_strobe),
    .symbol(symbol),
    .last_of_run(last_of_run),
    .stream_done(stream_done),
    .mismatch_count(mismatch_count),
    .pending_symbols(pending_symbols),
    .symbols_checked(symbols_checked)
  );

  task automatic conclude(input bit clean);
    $display("sent %0d requests: %0d loads, %0d decodes, %0d restarts, %0d unknown",
             loads_sent + decodes_sent + restarts_sent + unknown_sent,
             loads_sent, decodes_sent, restarts_sent, unknown_sent);
    $display("compared %0d decoded symbols, %0d mismatches", symbols_checked, mismatch_count);
    if (clean) begin
      $display("huffman_table_decoder_unit verification clean");
    end else begin
      $display("huffman_table_decoder_unit verification failed");
    end
    $finish;
  endtask

  // Hold start high until the request is taken; leave it high for the caller.
  task automatic issue(input logic [ACTION_W-1:0] act, input logic [SYM_W-1:0] sym,
                       input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                       input logic [BYTE_W-1:0] data_val);
    while (idle_on && $urandom_range(99, 0) < 26) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    symbol_value <= sym;
    code_bits <= code;
    code_len <= len;
    data_byte <= data_val;
    do @(posedge clk); while (busy);
    case (act)
      ACT_LOAD:    loads_sent++;
      ACT_DECODE:  decodes_sent++;
      ACT_RESTART: restarts_sent++;
      default:     unknown_sent++;
    endcase
    if (act != ACT_UNKNOWN) items_sent++;
  endtask

  task automatic decode_random();
    issue(ACT_DECODE, SYM_W'($urandom()), CODE_W'($urandom()), LEN_W'($urandom()),
          BYTE_W'($urandom()));
  endtask

  task automatic decode_fixed(input logic [BYTE_W-1:0] data_val);
    issue(ACT_DECODE, SYM_W'($urandom()), CODE_W'($urandom()), LEN_W'($urandom()), data_val);
  endtask

  task automatic load_fixed(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len);
    issue(ACT_LOAD, sym, code, len, BYTE_W'($urandom()));
  endtask

  task automatic restart();
    issue(ACT_RESTART, SYM_W'($urandom()), CODE_W'($urandom()), LEN_W'($urandom()),
          BYTE_W'($urandom()));
  endtask

  task automatic random_item();
    logic [LEN_W-1:0] len;
    len = ($urandom_range(1, 0) == 1) ? LEN_W'($urandom_range(16, 1)) : LEN_W'($urandom());
    issue(ACTION_W'($urandom()), SYM_W'($urandom()), CODE_W'($urandom()), len,
          BYTE_W'($urandom()));
  endtask

  // Drop start and wait for the block to drain every symbol and go quiet.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending_symbols != 0);
    repeat (12) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_total(input logic [COUNT_W-1:0] value);
    settle();
    symbol_total_we <= 1'b1;
    symbol_total <= value;
    @(posedge clk);
    symbol_total_we <= 1'b0;
  endtask

  // Canonical prefix code with random lengths and symbols; junk above the code bits.
  task automatic load_prefix_code(input int unsigned max_syms, input int unsigned max_len);
    int unsigned len;
    int unsigned grow;
    int unsigned word;
    int unsigned field;
    int unsigned n;
    bit          flip;
    len = $urandom_range(3, 1);
    if (len > max_len) len = max_len;
    word = 0;
    flip = $urandom_range(1, 0);
    for (n = 0; n < max_syms; n++) begin
      field = flip ? (~word & ((1 << len) - 1)) : word;
      field = field | ($urandom() << len);
      load_fixed(SYM_W'($urandom()), CODE_W'(field), LEN_W'(len));
      word++;
      if (word == (1 << len)) break;
      grow = $urandom_range(2, 0);
      if (len + grow > max_len) grow = max_len - len;
      len += grow;
      word <<= grow;
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    conclude(1'b0);
  end

  initial begin
    int unsigned          ep;
    int unsigned          n;
    int unsigned          runs;
    int unsigned          pick;
    logic [COUNT_W-1:0]   new_total;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    settle();

    // a zero total gives nothing
    write_total('0);
    load_fixed(8'h41, 16'h0000, 5'd1);
    decode_fixed(8'h00);

    write_total(TOTAL_MAX);
    load_fixed(8'h00, 16'h0002, 5'd2);
    load_fixed(8'hFF, 16'h0006, 5'd3);
    load_fixed(8'h80, 16'hFFFF, 5'd16);
    // loads of zero length or longer than the code limit are dropped
    load_fixed(8'h55, 16'hFFFF, 5'd0);
    load_fixed(8'h66, 16'h0000, 5'd17);
    load_fixed(8'h77, 16'h1234, 5'd31);
    issue(ACT_UNKNOWN, 8'hAA, 16'h5555, 5'd5, 8'h00);
    decode_fixed(8'h00);
    decode_fixed(8'hFF);
    decode_fixed(8'hFF);
    // a zero off the all-ones spine hits an empty entry
    decode_fixed(8'hFE);
    decode_fixed(8'h9B);
    decode_fixed(8'hA5);
    // overwrite a leaf with an internal node
    load_fixed(8'h07, 16'h0001, 5'd2);
    decode_fixed(8'h4C);

    // stop at the total mid-byte, then resume after raising it
    restart();
    write_total(32'd5);
    load_fixed(8'h41, 16'h0000, 5'd1);
    decode_fixed(8'h00);
    decode_fixed(8'h00);
    write_total(32'd7);
    decode_fixed(8'h00);

    for (ep = 0; items_sent < ITEM_TARGET; ep++) begin
      idle_on = !(ep >= 4 && ep < 8);
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
        // flood with long random codes to push past the store and toward a full tree
        restart();
        write_total(TOTAL_MAX);
        for (n = 0; n < 60; n++) begin
          load_fixed(SYM_W'($urandom()), CODE_W'($urandom()), LEN_W'($urandom_range(16, 10)));
        end
        for (n = 0; n < 12; n++) decode_random();
      end else if (pick == 1) begin
        for (n = 0; n < 16; n++) random_item();
      end else begin
        if ($urandom_range(3, 0) != 0) restart();
        pick = $urandom_range(9, 0);
        if (pick < 5) new_total = TOTAL_MAX;
        else if (pick < 9) new_total = COUNT_W'($urandom_range(40, 1));
        else new_total = COUNT_W'($urandom());
        write_total(new_total);
        load_prefix_code($urandom_range(16, 2), $urandom_range(16, 3));
        runs = $urandom_range(20, 6);
        for (n = 0; n < runs; n++) begin
          if ($urandom_range(19, 0) == 0) random_item();
          else decode_random();
        end
        if (new_total != TOTAL_MAX && $urandom_range(2, 0) == 0) begin
          write_total(new_total + COUNT_W'($urandom_range(12, 1)));
          for (n = 0; n < 6; n++) decode_random();
        end
      end
    end

    settle();
    conclude(mismatch_count == 0 && pending_symbols == 0);
  end

endmodule
